@@ hdl/distinct_permutation_generator_unit_macros.svh @@
// Assertion macros for the distinct permutation generator checker.
`ifndef DISTINCT_PERMUTATION_GENERATOR_UNIT_MACROS_SVH
`define DISTINCT_PERMUTATION_GENERATOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DPG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/dpg_pkg.sv @@
// Shared types and constants of the distinct permutation generator.
package dpg_pkg;

    localparam int DPG_MAX_ITEMS = 8;
    localparam int VALUE_BITS    = 16;
    localparam int CFG_BITS      = 4;

    localparam logic [CFG_BITS-1:0] ITEM_COUNT_RESET = 4'd8;
    localparam logic [CFG_BITS-1:0] ARR_LENGTH_RESET = 4'd1;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_NEXT = 1'b1
    } t_op;

    typedef enum logic {
        CFG_ITEM_COUNT = 1'b0,
        CFG_ARR_LENGTH = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_op                   op;
        logic [VALUE_BITS-1:0] value;
    } t_request;

    typedef struct packed {
        logic [VALUE_BITS-1:0] element;
        logic                  last_of_arrangement;
        logic                  exhausted;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_BACK,
        ST_SCAN,
        ST_EMIT,
        ST_EXH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_begin;
        logic load_step;
        logic next_first;
        logic next_resume;
        logic mark_done;
        logic back_step;
        logic scan_step;
        logic emit_step;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic no_arrangement;
        logic started;
        logic load_place;
        logic scan_end;
        logic scan_found;
        logic depth_zero;
        logic depth_last;
        logic emit_last;
    } t_dp_status;

endpackage

@@ hdl/dpg_ctrl.sv @@
// Control state machine that sequences loads, the search and the result requests.
module dpg_ctrl import dpg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_op        i_op,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_strobe
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_op == OP_LOAD) begin
                        if (!i_status.full) begin
                            n_state = ST_LOAD;
                        end
                    end else if (i_status.no_arrangement) begin
                        n_state = ST_EXH;
                    end else if (!i_status.started) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_BACK;
                    end
                end
            end
            ST_LOAD: begin
                if (i_status.load_place) begin
                    n_state = ST_IDLE;
                end
            end
            ST_BACK: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_status.scan_end) begin
                    n_state = i_status.depth_zero ? ST_EXH : ST_BACK;
                end else if (i_status.scan_found && i_status.depth_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EXH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd    = '0;
        o_busy   = 1'b1;
        o_strobe = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    if (i_op == OP_LOAD) begin
                        o_cmd.load_begin = !i_status.full;
                    end else if (i_status.no_arrangement) begin
                        o_cmd.mark_done = 1'b1;
                    end else if (!i_status.started) begin
                        o_cmd.next_first = 1'b1;
                    end else begin
                        o_cmd.next_resume = 1'b1;
                    end
                end
            end
            ST_LOAD: begin
                o_cmd.load_step = 1'b1;
            end
            ST_BACK: begin
                o_cmd.back_step = 1'b1;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.emit_step = 1'b1;
                o_strobe        = 1'b1;
            end
            ST_EXH: begin
                o_strobe = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

@@ hdl/dpg_datapath.sv @@
// Datapath: sorted store, search state, configuration registers and result forming.
module dpg_datapath import dpg_pkg::*; #(
    parameter int MAX_ITEMS = DPG_MAX_ITEMS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  t_cfg_index          i_cfg_index,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    input  t_request            i_request,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    output t_result             o_result
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int NW    = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;

    // Control state.
    logic [CFG_BITS-1:0]   r_item_count;
    logic [CFG_BITS-1:0]   r_arr_len;
    logic [CNT_W-1:0]      r_loaded;
    logic [MAX_ITEMS-1:0]  r_used;
    logic                  r_started;
    logic                  r_done;

    // Payload state.
    logic [VALUE_BITS-1:0] r_store  [MAX_ITEMS];
    logic [IDX_W-1:0]      r_chosen [MAX_ITEMS];
    logic [VALUE_BITS-1:0] r_key;
    logic [CNT_W-1:0]      r_scan;
    logic [CNT_W-1:0]      r_depth;
    logic [CNT_W-1:0]      r_emit;
    logic                  r_has_prev;

    logic [NW-1:0]         w_n;
    logic [NW-1:0]         w_m;
    logic [IDX_W-1:0]      w_cur;
    logic [IDX_W-1:0]      w_rd_addr;
    logic [VALUE_BITS-1:0] w_rdata;
    logic                  w_load_place;
    logic                  w_scan_end;
    logic                  w_scan_found;
    logic                  w_depth_zero;
    logic                  w_restart;

    // The usable multiset is the lower of the configured and the loaded count.
    assign w_n = (NW'(r_item_count) < NW'(r_loaded)) ? NW'(r_item_count) : NW'(r_loaded);
    assign w_m = NW'(r_arr_len);

    assign w_cur = r_chosen[r_depth[IDX_W-1:0]];

    // The store has one read port; the active step picks its address.
    always_comb begin
        priority if (i_cmd.load_step) begin
            w_rd_addr = r_scan[IDX_W-1:0] - IDX_W'(1);
        end else if (i_cmd.back_step) begin
            w_rd_addr = w_cur;
        end else if (i_cmd.emit_step) begin
            w_rd_addr = r_chosen[r_emit[IDX_W-1:0]];
        end else begin
            w_rd_addr = r_scan[IDX_W-1:0];
        end
    end

    assign w_rdata = r_store[w_rd_addr];

    assign w_load_place = !((r_scan != '0) && (w_rdata > r_key));
    assign w_scan_end   = (NW'(r_scan) >= w_n);
    assign w_scan_found = !w_scan_end && !r_used[r_scan[IDX_W-1:0]]
                          && !(r_has_prev && (w_rdata == r_key));
    assign w_depth_zero = (r_depth == '0);
    assign w_restart    = i_cfg_we || (i_cmd.load_step && w_load_place);

    assign o_status.full           = (r_loaded == CNT_W'(MAX_ITEMS));
    assign o_status.no_arrangement = r_done || (w_m == '0) || (w_m > w_n);
    assign o_status.started        = r_started;
    assign o_status.load_place     = w_load_place;
    assign o_status.scan_end       = w_scan_end;
    assign o_status.scan_found     = w_scan_found;
    assign o_status.depth_zero     = w_depth_zero;
    assign o_status.depth_last     = ((NW'(r_depth) + NW'(1)) == w_m);
    assign o_status.emit_last      = ((NW'(r_emit) + NW'(1)) == w_m);

    assign o_result.element             = i_cmd.emit_step ? w_rdata : '0;
    assign o_result.last_of_arrangement = i_cmd.emit_step && o_status.emit_last;
    assign o_result.exhausted           = !i_cmd.emit_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_count <= ITEM_COUNT_RESET;
            r_arr_len    <= ARR_LENGTH_RESET;
            r_loaded     <= '0;
            r_used       <= '0;
            r_started    <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ITEM_COUNT: r_item_count <= i_cfg_data;
                    CFG_ARR_LENGTH: r_arr_len    <= i_cfg_data;
                endcase
            end
            if (i_cmd.load_step && w_load_place) begin
                r_loaded <= r_loaded + CNT_W'(1);
            end
            if (i_cmd.next_first) begin
                r_started <= 1'b1;
            end
            if (i_cmd.mark_done || (i_cmd.scan_step && w_scan_end && w_depth_zero)) begin
                r_done <= 1'b1;
            end
            if (i_cmd.back_step) begin
                r_used[w_cur] <= 1'b0;
            end
            if (i_cmd.scan_step && w_scan_found) begin
                r_used[r_scan[IDX_W-1:0]] <= 1'b1;
            end
            if (w_restart) begin
                r_used    <= '0;
                r_started <= 1'b0;
                r_done    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_begin) begin
            r_key  <= i_request.value;
            r_scan <= r_loaded;
        end
        // Insertion walks down from the top, moving larger values up one slot.
        if (i_cmd.load_step) begin
            if (w_load_place) begin
                r_store[r_scan[IDX_W-1:0]] <= r_key;
            end else begin
                r_store[r_scan[IDX_W-1:0]] <= w_rdata;
                r_scan                     <= r_scan - CNT_W'(1);
            end
        end
        if (i_cmd.next_first) begin
            r_depth    <= '0;
            r_scan     <= '0;
            r_has_prev <= 1'b0;
        end
        if (i_cmd.next_resume) begin
            r_depth <= CNT_W'(w_m - NW'(1));
        end
        // Release the index at this depth and look past it for a different value.
        if (i_cmd.back_step) begin
            r_key      <= w_rdata;
            r_has_prev <= 1'b1;
            r_scan     <= CNT_W'(w_cur) + CNT_W'(1);
        end
        if (i_cmd.scan_step) begin
            if (w_scan_end) begin
                if (!w_depth_zero) begin
                    r_depth <= r_depth - CNT_W'(1);
                end
            end else if (w_scan_found) begin
                r_chosen[r_depth[IDX_W-1:0]] <= r_scan[IDX_W-1:0];
                r_depth                      <= r_depth + CNT_W'(1);
                r_scan                       <= '0;
                r_has_prev                   <= 1'b0;
                r_emit                       <= '0;
            end else begin
                r_scan <= r_scan + CNT_W'(1);
            end
        end
        if (i_cmd.emit_step) begin
            r_emit <= r_emit + CNT_W'(1);
        end
    end

endmodule

@@ hdl/distinct_permutation_generator_unit.sv @@
// Top level of the distinct permutation generator.
//
// The block enumerates, in lexicographic order, every distinct arrangement of
// arrangement_length values drawn from a loaded multiset. A request is taken
// when start is high and busy is low. A load request inserts its value into an
// ascending sorted store (equal values go after those already present) and
// restarts the search; it gives no result and keeps busy high while it moves
// each stored value larger than the new one up one slot, then places the new
// value. A load into a full store is dropped without any busy time. A next
// request runs the depth-first search one store index per cycle, backtracking
// one depth at a time, then presents the m elements of the arrangement on
// consecutive cycles, each for exactly one cycle with o_strobe high, the final
// one with last_of_arrangement set. When no arrangement remains, or the length
// is zero or larger than min(item_count, loaded values), a next request gives
// a single exhausted result with element zero, and the block stays exhausted
// until a load, a register write or a reset. The receiver cannot stall: results
// must be taken in the cycle they appear. Configuration writes are always ready
// and must only be issued while busy is low; each write restarts the search.
module distinct_permutation_generator_unit import dpg_pkg::*; #(
    parameter int MAX_ITEMS = DPG_MAX_ITEMS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  t_request            i_request,
    output logic                o_strobe,
    output t_result             o_result,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  t_cfg_index          i_cfg_index,
    input  logic [CFG_BITS-1:0] i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // The register file takes a write in every cycle.
    assign o_cfg_ready = 1'b1;

    dpg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_op     (i_request.op),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    dpg_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_request   (i_request),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_result    (o_result)
    );

endmodule

@@ hdl/dpg_checker.sv @@
// Port-level checker for the distinct permutation generator and its bind.
`include "distinct_permutation_generator_unit_macros.svh"

module dpg_checker import dpg_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input t_request            i_request,
    input logic                o_strobe,
    input t_result             o_result,
    input logic                i_cfg_valid,
    input logic                o_cfg_ready
);

    // Results only appear while a next request is being worked on.
    `DPG_ASSERT_NOW(a_strobe_busy, o_strobe, busy, "result shown while idle")

    // An exhausted result carries no element.
    `DPG_ASSERT_NOW(a_exh_form, o_strobe && o_result.exhausted,
        (o_result.element == '0) && !o_result.last_of_arrangement,
        "malformed exhausted result")

    // The final element or an exhausted result ends the request.
    `DPG_ASSERT_NEXT(a_end_idle,
        o_strobe && (o_result.exhausted || o_result.last_of_arrangement),
        !busy && !o_strobe, "request did not end")

    // Every accepted next request produces work.
    `DPG_ASSERT_NEXT(a_next_busy, start && !busy && (i_request.op == OP_NEXT), busy,
        "next request ignored")

    // The user must let register writes land only while no request is in flight; this assertion checks it.
    `DPG_ASSERT_NOW(a_cfg_idle, i_cfg_valid && o_cfg_ready, !busy, "register write while busy")

endmodule

bind distinct_permutation_generator_unit dpg_checker u_dpg_checker (.*);
